>>> sv/lpfp_pkg.sv
// Shared types and constants for the length-prefixed frame parser.
`default_nettype none

package lpfp_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 32;
  localparam int unsigned OUT_USER_W = 10;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 32'd1048576;

  // One parsed result, as handed from the parse core to the output register.
  typedef struct packed {
    logic              frame_error;
    logic              last_of_frame;
    logic              has_byte;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] frame_kind;
  } result_t;

endpackage

`default_nettype wire

>>> sv/length_prefixed_frame_parser.sv
// Top level of the length-prefixed frame parser: ports, config, output register.
//
//   channel  dir  signals                               contents (low bit up)
//   in_      in   in_tvalid/in_tready/in_tdata[7:0]      rx_byte
//   out_     out  out_tvalid/out_tready/out_tdata[7:0]   payload_byte
//                 out_tuser[9:0], out_tlast              kind, has_byte, error; last
//   cfg_     in   cfg_wr_en/cfg_wr_data[31:0]            max_frame_length
//
// One byte per cycle: each request is parsed in the cycle it is taken and
// its result (if any) lands in the output register on the same edge.
// Throughput is set by the output register alone; in_tready drops only
// while a result waits and out_tready is low.
// Reset (rst_n low, synchronous) clears parse state, the sticky error and
// the output valid, and sets the maximum length to 1048576.
// After a bad length, requests are still taken but give no result.
`default_nettype none

module length_prefixed_frame_parser (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // in_tdata: [7:0] rx_byte
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [lpfp_pkg::BYTE_W-1:0]          in_tdata,
  // out_tdata: [7:0] payload_byte
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [lpfp_pkg::BYTE_W-1:0]               out_tdata,
  // out_tuser: [7:0] frame_kind, [8] has_byte, [9] frame_error
  output logic [lpfp_pkg::OUT_USER_W-1:0]           out_tuser,
  output logic                                      out_tlast,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [lpfp_pkg::LEN_W-1:0]           cfg_wr_data
);
  import lpfp_pkg::*;

  logic [LEN_W-1:0] max_len_r;
  logic             out_valid_r;
  result_t          out_res_r;
  logic             step;
  logic             res_valid;
  result_t          res;

  // a request is taken whenever the output register is free or emptying
  assign in_tready = !out_valid_r || out_tready;
  assign step      = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  lpfp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (in_tdata),
    .max_len   (max_len_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register; payload needs no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= res_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.payload_byte;
  assign out_tuser  = {out_res_r.frame_error, out_res_r.has_byte, out_res_r.frame_kind};
  assign out_tlast  = out_res_r.last_of_frame;

endmodule

`default_nettype wire

>>> sv/lpfp_core.sv
// Parse state machine: length field, kind byte, payload count, sticky error.
`default_nettype none

module lpfp_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      step,
  input  wire logic [lpfp_pkg::BYTE_W-1:0] rx_byte,
  input  wire logic [lpfp_pkg::LEN_W-1:0]  max_len,
  output logic                           res_valid,
  output lpfp_pkg::result_t              res
);
  import lpfp_pkg::*;

  typedef enum logic [2:0] {
    PH_LEN0    = 3'd0,
    PH_LEN1    = 3'd1,
    PH_LEN2    = 3'd2,
    PH_LEN3    = 3'd3,
    PH_KIND    = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_ERROR   = 3'd6
  } phase_t;

  localparam int unsigned ACC_W = LEN_W - BYTE_W;

  phase_t              phase_r, phase_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [LEN_W-1:0]    rem_r, rem_nxt;
  logic [BYTE_W-1:0]   kind_r, kind_nxt;
  logic [LEN_W-1:0]    full_len;

  assign full_len = {rx_byte, acc_r};

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    kind_nxt  = kind_r;
    res_valid = 1'b0;
    res       = '0;
    case (phase_r)
      PH_LEN1: begin
        acc_nxt[2*BYTE_W-1:BYTE_W] = rx_byte;
        phase_nxt = PH_LEN2;
      end
      PH_LEN2: begin
        acc_nxt[3*BYTE_W-1:2*BYTE_W] = rx_byte;
        phase_nxt = PH_LEN3;
      end
      PH_LEN3: begin
        acc_nxt = '0;
        if (full_len == '0 || full_len > max_len) begin
          // bad length: one error result, then silent until reset
          phase_nxt       = PH_ERROR;
          rem_nxt         = '0;
          res_valid       = 1'b1;
          res.frame_error = 1'b1;
        end else begin
          rem_nxt   = full_len - LEN_W'(1);
          phase_nxt = PH_KIND;
        end
      end
      PH_KIND: begin
        kind_nxt = rx_byte;
        if (rem_r == '0) begin
          // empty payload: a single marked result with no byte
          phase_nxt         = PH_LEN0;
          res_valid         = 1'b1;
          res.frame_kind    = rx_byte;
          res.last_of_frame = 1'b1;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        rem_nxt           = (rem_r == '0) ? '0 : rem_r - LEN_W'(1);
        res_valid         = 1'b1;
        res.frame_kind    = kind_r;
        res.payload_byte  = rx_byte;
        res.has_byte      = 1'b1;
        res.last_of_frame = (rem_r <= LEN_W'(1));
        if (rem_r <= LEN_W'(1)) begin
          phase_nxt = PH_LEN0;
        end
      end
      PH_ERROR: begin
        // sticky: bytes are taken and dropped
      end
      default: begin
        // first length byte; unused codes behave the same
        acc_nxt   = {{(ACC_W-BYTE_W){1'b0}}, rx_byte};
        phase_nxt = PH_LEN1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEN0;
      acc_r   <= '0;
      rem_r   <= '0;
      kind_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      rem_r   <= rem_nxt;
      kind_r  <= kind_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/lpfp_checker.sv
// Port-level checks for the frame parser, bound to the top level.
`default_nettype none

module lpfp_checker (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 in_tready,
  input wire logic                                 out_tvalid,
  input wire logic                                 out_tready,
  input wire logic [lpfp_pkg::BYTE_W-1:0]          out_tdata,
  input wire logic [lpfp_pkg::OUT_USER_W-1:0]      out_tuser,
  input wire logic                                 out_tlast
);
  import lpfp_pkg::*;

  // an empty output register never holds off the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("in_tready low with no result pending");

  // error result carries nothing else
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[9]) |->
      (out_tuser[8:0] == '0 && out_tdata == '0 && !out_tlast))
    else $error("error result with stray fields");

  // a byteless non-error result is the whole of an empty frame
  a_empty_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[9] && !out_tuser[8]) |->
      (out_tlast && out_tdata == '0))
    else $error("byteless result not marked last");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled result changed");

endmodule

bind length_prefixed_frame_parser lpfp_checker u_lpfp_checker (.*);

`default_nettype wire
